>>> rtl/core/oma_pkg.sv
// Shared widths, defaults and register map for the offset moving average unit.
package oma_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int WINDOW_DEFAULT = 8;
  localparam int WINDOW_MAX     = 64;

  // Configuration register map
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic REG_BASELINE_OFFSET = 1'b0;

endpackage

>>> rtl/core/offset_moving_average_unit.sv
// Offset moving average unit: baseline subtract, window ring, shared-adder divider.
//
// Usage: one signed 16-bit sample per request on the sample channel
// (sample_valid / sample_stall). The configured baseline offset is
// subtracted with 16-bit wrap, the corrected value replaces the oldest entry
// of a WINDOW-deep ring, and the running sum divided by the number of samples
// seen (capped at WINDOW) comes out on the result channel
// (result_valid / result_stall), truncated toward zero.
// The sum is SUM_W = 16 + log2(WINDOW) bits wide. One request is in flight at
// a time; the block raises sample_stall while busy, so no new sample is taken
// until the last one's result is in the output register. The cost is set by
// the restoring divider, one quotient bit per cycle through the single shared
// add/subtract unit.
// A finished result sits in an output register; the next sample is taken
// while it waits. If the receiver stalls and a second result is ready, the
// sequencer holds until the output register frees.
// Reset clears the baseline offset, running sum, fill count and write slot;
// ring entries are treated as zero until the ring has filled once.
// baseline_offset is written over the APB port at any address with paddr[2] = 0 (0 to 3).
module offset_moving_average_unit
  import oma_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_ADDR_W-1:0]        paddr,
  input  logic [APB_DATA_W-1:0]        pwdata,
  output logic [APB_DATA_W-1:0]        prdata,
  output logic                         pready,
  // samples
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  logic signed [SAMPLE_W-1:0]   raw_accel,
  // results
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic signed [SAMPLE_W-1:0]   smoothed_accel
);

  localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int COUNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW);
  localparam int ALU_W   = SUM_W + 1;
  localparam int BIT_W   = $clog2(SUM_W);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUB  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_ABS  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_SIGN = 3'd5;

  logic [2:0]                 state;
  logic signed [SAMPLE_W-1:0] baseline_offset;
  logic [SAMPLE_W-1:0]        sample;
  logic [SLOT_W-1:0]          write_slot;
  logic [COUNT_W-1:0]         fill_count;
  logic [SUM_W-1:0]           running_total;
  logic [SUM_W-1:0]           quo;
  logic [COUNT_W-1:0]         rem;
  logic [BIT_W-1:0]           bit_cnt;
  logic                       neg;

  logic [SAMPLE_W-1:0]        ring [WINDOW];
  logic [SAMPLE_W-1:0]        ring_rd;
  logic                       ring_we;

  logic [ALU_W-1:0]           alu_a;
  logic [ALU_W-1:0]           alu_b;
  logic                       alu_sub;
  logic [ALU_W-1:0]           alu_y;

  logic                       sample_take;
  logic                       cfg_write;
  logic                       ring_full;
  logic [SAMPLE_W-1:0]        old_sample;
  logic [COUNT_W:0]           shifted;
  logic                       result_load;

  assign pready       = 1'b1;
  assign prdata       = APB_DATA_W'(baseline_offset);
  assign cfg_write    = psel && penable && pwrite && pready;
  assign sample_stall = (state != S_IDLE);
  assign sample_take  = sample_valid && !sample_stall;
  assign ring_full    = (fill_count == COUNT_W'(WINDOW));
  // entries not yet written since reset read as zero
  assign old_sample   = ring_full ? ring_rd : '0;
  assign shifted      = {rem, quo[SUM_W-1]};
  assign ring_we      = (state == S_SUB);
  assign result_load  = (state == S_SIGN) && (!result_valid || !result_stall);

  // shared add/subtract unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      S_SUB: begin
        alu_a   = {running_total[SUM_W-1], running_total};
        alu_b   = {{(ALU_W-SAMPLE_W){old_sample[SAMPLE_W-1]}}, old_sample};
        alu_sub = 1'b1;
      end
      S_ADD: begin
        alu_a   = {running_total[SUM_W-1], running_total};
        alu_b   = {{(ALU_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
      end
      S_ABS: begin
        alu_b   = {running_total[SUM_W-1], running_total};
        alu_sub = running_total[SUM_W-1];
      end
      S_DIV: begin
        alu_a   = {{(ALU_W-COUNT_W-1){1'b0}}, shifted};
        alu_b   = {{(ALU_W-COUNT_W){1'b0}}, fill_count};
        alu_sub = 1'b1;
      end
      S_SIGN: begin
        alu_b   = {1'b0, quo};
        alu_sub = neg;
      end
      default: begin
        alu_a   = '0;
      end
    endcase
    alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[write_slot] <= sample;
    end
    ring_rd <= ring[write_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      baseline_offset <= '0;
      write_slot      <= '0;
      fill_count      <= '0;
      running_total   <= '0;
      result_valid    <= 1'b0;
    end else begin
      if (cfg_write && (paddr[2] == REG_BASELINE_OFFSET)) begin
        baseline_offset <= pwdata[SAMPLE_W-1:0];
      end
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample_take) begin
            sample <= raw_accel - baseline_offset;
            state  <= S_SUB;
          end
        end
        S_SUB: begin
          running_total <= alu_y[SUM_W-1:0];
          if (write_slot == SLOT_W'(WINDOW - 1)) begin
            write_slot <= '0;
          end else begin
            write_slot <= write_slot + 1'b1;
          end
          if (!ring_full) begin
            fill_count <= fill_count + 1'b1;
          end
          state <= S_ADD;
        end
        S_ADD: begin
          running_total <= alu_y[SUM_W-1:0];
          state         <= S_ABS;
        end
        S_ABS: begin
          quo     <= alu_y[SUM_W-1:0];
          neg     <= running_total[SUM_W-1];
          rem     <= '0;
          bit_cnt <= BIT_W'(SUM_W - 1);
          state   <= S_DIV;
        end
        S_DIV: begin
          // restoring step: keep the difference when it did not go negative
          if (!alu_y[ALU_W-1]) begin
            rem <= alu_y[COUNT_W-1:0];
          end else begin
            rem <= shifted[COUNT_W-1:0];
          end
          quo <= {quo[SUM_W-2:0], ~alu_y[ALU_W-1]};
          if (bit_cnt == '0) begin
            state <= S_SIGN;
          end else begin
            bit_cnt <= bit_cnt - 1'b1;
          end
        end
        S_SIGN: begin
          if (result_load) begin
            smoothed_accel <= alu_y[SAMPLE_W-1:0];
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/oma_checker.sv
// Port-level checks for the offset moving average unit, bound to the top level.
module oma_checker
  import oma_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       sample_valid,
  input logic                       sample_stall,
  input logic                       result_valid,
  input logic                       result_stall,
  input logic [SAMPLE_W-1:0]        smoothed_accel
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(smoothed_accel))
    else $error("result changed while stalled");

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid && !sample_stall)
    else $error("block not idle after reset");

  // an accepted request makes the block busy, with no new result raised
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall && !$rose(result_valid))
    else $error("block not busy after accepting a request");

  // a new result is loaded only as the block returns to idle
  a_idle_with_result: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !sample_stall)
    else $error("result appeared while block still busy");

endmodule

bind offset_moving_average_unit oma_checker u_oma_checker (.*);
